FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; every use samples on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/tpac_pkg.sv
// ----------------------------------------------------------------------------
// Triac phase-angle controller package
// Shared widths, codes, reset values and the structures passed between units.
// ----------------------------------------------------------------------------
package tpac_pkg;

  localparam int unsigned PCT_W   = 7;
  localparam int unsigned DELAY_W = 13;
  localparam int unsigned QUIET_W = 20;
  localparam int unsigned CFG_W   = 20;

  // Command codes carried in op.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ENABLE  = 2'd1;
  localparam logic [1:0] OP_DISABLE = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Latched error codes.
  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_NOT_CONDUCTING = 2'd1;
  localparam logic [1:0] ERR_NOT_INSULATING = 2'd2;

  // Register indexes.
  localparam logic REG_PERCENT = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  // Percent clamp and delay table corners.
  localparam logic [PCT_W-1:0]   PCT_MIN      = 7'd1;
  localparam logic [PCT_W-1:0]   PCT_MAX      = 7'd99;
  localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
  localparam logic [DELAY_W-1:0] DELAY_AT_MIN = 13'd6188;
  localparam logic [DELAY_W-1:0] DELAY_AT_MAX = 13'd62;
  // 625 / 10 ticks per percent, taken as 125 then halved.
  localparam logic [DELAY_W:0]   DELAY_STEP   = 14'd125;

  localparam logic [PCT_W-1:0]   PCT_RESET     = 7'd90;
  localparam logic [DELAY_W-1:0] DELAY_RESET   = 13'd625;
  localparam logic [QUIET_W-1:0] TIMEOUT_RESET = 20'd156250;
  localparam logic [QUIET_W-1:0] QUIET_MAX     = '1;

  typedef struct packed {
    logic [PCT_W-1:0]   percent;
    logic [DELAY_W-1:0] delay;
    logic [QUIET_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic             gate_drive;
    logic             enabled;
    logic [1:0]       error_code;
    logic [PCT_W-1:0] applied_percent;
  } result_t;

endpackage

FILE: rtl/core/tpac_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the clamped percent, its gate delay and the watchdog limit, all
// worked out when the register is written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpac_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tpac_pkg::CFG_W-1:0] cfg_data,
  output tpac_pkg::cfg_t             cfg
);

  logic [tpac_pkg::PCT_W-1:0]   raw_pct;
  logic [tpac_pkg::PCT_W-1:0]   pct_clamped;
  logic [tpac_pkg::PCT_W-1:0]   pct_gap;
  logic [tpac_pkg::DELAY_W:0]   delay_prod;
  logic [tpac_pkg::DELAY_W-1:0] delay_new;
  logic [tpac_pkg::QUIET_W-1:0] limit_new;

  always_comb begin
    raw_pct = cfg_data[tpac_pkg::PCT_W-1:0];
    priority if (raw_pct >= tpac_pkg::PCT_MAX) begin
      pct_clamped = tpac_pkg::PCT_MAX;
    end else if (raw_pct <= tpac_pkg::PCT_MIN) begin
      pct_clamped = tpac_pkg::PCT_MIN;
    end else begin
      pct_clamped = raw_pct;
    end
    pct_gap    = tpac_pkg::PCT_FULL - pct_clamped;
    delay_prod = (tpac_pkg::DELAY_W+1)'(pct_gap) * tpac_pkg::DELAY_STEP;
    // The end points keep their own rounded values.
    priority if (pct_clamped == tpac_pkg::PCT_MAX) begin
      delay_new = tpac_pkg::DELAY_AT_MAX;
    end else if (pct_clamped == tpac_pkg::PCT_MIN) begin
      delay_new = tpac_pkg::DELAY_AT_MIN;
    end else begin
      delay_new = delay_prod[tpac_pkg::DELAY_W:1];
    end
    // A zero timeout behaves as one tick.
    if (cfg_data[tpac_pkg::QUIET_W-1:0] == '0) begin
      limit_new = tpac_pkg::QUIET_W'(1);
    end else begin
      limit_new = cfg_data[tpac_pkg::QUIET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.percent <= tpac_pkg::PCT_RESET;
      cfg.delay   <= tpac_pkg::DELAY_RESET;
      cfg.limit   <= tpac_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tpac_pkg::REG_PERCENT) begin
        cfg.percent <= pct_clamped;
        cfg.delay   <= delay_new;
      end else begin
        cfg.limit <= limit_new;
      end
    end
  end

  `ASSERT_CLK(a_pct_range,
    cfg.percent >= tpac_pkg::PCT_MIN && cfg.percent <= tpac_pkg::PCT_MAX,
    "applied percent left 1..99")
  `ASSERT_CLK(a_limit_nonzero, cfg.limit != '0, "watchdog limit is zero")

endmodule

FILE: rtl/core/tpac_ctrl.sv
// ----------------------------------------------------------------------------
// Gate control state
// Edge detection, one-shot delay, watchdog and error latch; one item per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpac_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           step_op,
  input  logic                 step_level,
  input  tpac_pkg::cfg_t       cfg,
  output tpac_pkg::result_t    result_next
);

  logic                         ctrl_active, ctrl_active_next;
  logic                         gate_level, gate_level_next;
  logic [tpac_pkg::DELAY_W-1:0] delay_left, delay_left_next;
  logic                         delay_running, delay_running_next;
  logic [tpac_pkg::QUIET_W-1:0] quiet_count, quiet_count_next;
  logic                         previous_level, previous_level_next;
  logic [1:0]                   fault, fault_next;
  logic [tpac_pkg::DELAY_W-1:0] delay_dec;
  logic [tpac_pkg::QUIET_W-1:0] quiet_inc;

  always_comb begin
    ctrl_active_next    = ctrl_active;
    gate_level_next     = gate_level;
    delay_left_next     = delay_left;
    delay_running_next  = delay_running;
    quiet_count_next    = quiet_count;
    previous_level_next = previous_level;
    fault_next          = fault;
    delay_dec = (delay_left != '0) ? delay_left - tpac_pkg::DELAY_W'(1) : delay_left;
    quiet_inc = (quiet_count != tpac_pkg::QUIET_MAX) ?
                quiet_count + tpac_pkg::QUIET_W'(1) : quiet_count;

    unique case (step_op)
      tpac_pkg::OP_TICK: begin
        if (step_level != previous_level) begin
          previous_level_next = step_level;
          if (!ctrl_active) begin
            delay_running_next = 1'b0;
            gate_level_next    = 1'b0;
          end else begin
            quiet_count_next = '0;
            if (step_level) begin
              delay_left_next    = cfg.delay;
              delay_running_next = 1'b1;
            end else begin
              delay_running_next = 1'b0;
              gate_level_next    = 1'b0;
            end
          end
        end else begin
          if (delay_running) begin
            delay_left_next = delay_dec;
            if (delay_dec == '0) begin
              delay_running_next = 1'b0;
              gate_level_next    = ctrl_active;
            end
          end
          if (ctrl_active) begin
            quiet_count_next = quiet_inc;
            if (quiet_inc >= cfg.limit) begin
              ctrl_active_next = 1'b0;
              gate_level_next  = 1'b0;
              fault_next = step_level ? tpac_pkg::ERR_NOT_INSULATING
                                      : tpac_pkg::ERR_NOT_CONDUCTING;
            end
          end
        end
      end
      tpac_pkg::OP_ENABLE: begin
        if (fault == tpac_pkg::ERR_NONE) begin
          ctrl_active_next    = 1'b1;
          previous_level_next = step_level;
          quiet_count_next    = '0;
          if (step_level) begin
            delay_left_next    = cfg.delay;
            delay_running_next = 1'b1;
          end else begin
            delay_running_next = 1'b0;
            gate_level_next    = 1'b0;
          end
        end
      end
      tpac_pkg::OP_DISABLE: begin
        ctrl_active_next = 1'b0;
      end
      tpac_pkg::OP_CLEAR: begin
        fault_next = tpac_pkg::ERR_NONE;
      end
      default: begin
        ctrl_active_next = ctrl_active;
      end
    endcase

    result_next.gate_drive      = gate_level_next;
    result_next.enabled         = ctrl_active_next;
    result_next.error_code      = fault_next;
    result_next.applied_percent = cfg.percent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_active    <= 1'b0;
      gate_level     <= 1'b0;
      delay_left     <= '0;
      delay_running  <= 1'b0;
      quiet_count    <= '0;
      previous_level <= 1'b0;
      fault          <= tpac_pkg::ERR_NONE;
    end else if (step) begin
      ctrl_active    <= ctrl_active_next;
      gate_level     <= gate_level_next;
      delay_left     <= delay_left_next;
      delay_running  <= delay_running_next;
      quiet_count    <= quiet_count_next;
      previous_level <= previous_level_next;
      fault          <= fault_next;
    end
  end

  `ASSERT_ALWAYS(a_fault_blocks_on, fault != tpac_pkg::ERR_NONE |-> !ctrl_active,
    "control on while an error is latched")
  `ASSERT_CLK(a_delay_bound, !delay_running || delay_left <= tpac_pkg::DELAY_AT_MIN,
    "running delay beyond the longest setting")
  `ASSERT_CLK(a_idle_holds, !step |=> $stable(fault) && $stable(ctrl_active),
    "state moved without an item")

endmodule

FILE: rtl/core/triac_phase_angle_controller.sv
// ----------------------------------------------------------------------------
// Triac phase-angle controller
// An accepted item passes through the input register and then the result register.
// Throughput: one item per clock unless the receiver stalls; the only stage is
// the control update between the input register and the result register.
// Reset (synchronous, active high) empties both stages, switches control off,
// clears the error and loads percent 90 and a 156250-tick watchdog limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triac_phase_angle_controller (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration write port.
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tpac_pkg::CFG_W-1:0]  cfg_data,
  // Input channel.
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic                        sense_level,
  // Result channel.
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        gate_drive,
  output logic                        enabled,
  output logic [1:0]                  error_code,
  output logic [tpac_pkg::PCT_W-1:0]  applied_percent
);

  tpac_pkg::cfg_t    cfg;
  tpac_pkg::result_t result_next;
  tpac_pkg::result_t result;

  // Input register: one beat waits here for its turn at the control update.
  logic       in_full;
  logic [1:0] in_op;
  logic       in_level;
  logic       advance;

  // The held beat moves on whenever the result register is empty or being
  // emptied in this same cycle, so a result that is collected in this cycle
  // does not stop the next beat from being taken in.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_op    <= op;
      in_level <= sense_level;
    end
  end

  tpac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The control state commits exactly when its beat enters the result
  // register, so state and delivered results stay in step.
  tpac_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .step_op     (in_op),
    .step_level  (in_level),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Result register: holds its beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign gate_drive      = result.gate_drive;
  assign enabled         = result.enabled;
  assign error_code      = result.error_code;
  assign applied_percent = result.applied_percent;

  `ASSERT_CLK(a_advance_fills, advance |=> out_valid, "advanced beat lost")
  `ASSERT_CLK(a_stall_needs_full, in_stall |-> in_full && out_valid && out_stall,
    "input stalled without a blocked result")

endmodule

FILE: dv/tpac_gate_checker.sv
// ----------------------------------------------------------------------------
// Triac phase-angle controller checker
// Watches the register port and both channels of the controller, predicts the
// result of every accepted input beat and compares each result beat with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tpac_gate_checker
  import tpac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic               sense_level,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               gate_drive,
  input  logic               enabled,
  input  logic [1:0]         error_code,
  input  logic [PCT_W-1:0]   applied_percent,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the register file.
  logic [PCT_W-1:0]   percent_request;
  logic [QUIET_W-1:0] timeout_ticks;

  // Shadow of the control state.
  logic               ctrl_active;
  logic               gate_level;
  logic [DELAY_W-1:0] delay_left;
  logic               delay_running;
  logic [QUIET_W-1:0] quiet_count;
  logic               previous_level;
  logic [1:0]         fault;

  result_t expected_results[$];

  function automatic logic [PCT_W-1:0] clamp_percent(logic [PCT_W-1:0] req);
    if (req >= PCT_MAX) return PCT_MAX;
    if (req <= PCT_MIN) return PCT_MIN;
    return req;
  endfunction

  function automatic logic [DELAY_W-1:0] firing_delay(logic [PCT_W-1:0] req);
    logic [PCT_W-1:0] pct;
    int unsigned      ticks;
    pct = clamp_percent(req);
    if (pct == PCT_MAX) return DELAY_AT_MAX;
    if (pct == PCT_MIN) return DELAY_AT_MIN;
    ticks = (625 * (int'(PCT_FULL) - int'(pct))) / 10;
    return ticks[DELAY_W-1:0];
  endfunction

  function automatic void follow_level(logic level);
    quiet_count = '0;
    if (level) begin
      delay_left    = firing_delay(percent_request);
      delay_running = 1'b1;
    end else begin
      delay_running = 1'b0;
      gate_level    = 1'b0;
    end
  endfunction

  function automatic void take_tick(logic level);
    logic [QUIET_W-1:0] limit;
    if (level != previous_level) begin
      previous_level = level;
      if (!ctrl_active) begin
        delay_running = 1'b0;
        gate_level    = 1'b0;
      end else begin
        follow_level(level);
      end
      return;
    end
    if (delay_running) begin
      if (delay_left != '0) delay_left = delay_left - 1'b1;
      if (delay_left == '0) begin
        delay_running = 1'b0;
        gate_level    = ctrl_active;
      end
    end
    if (ctrl_active) begin
      limit = (timeout_ticks == '0) ? QUIET_W'(1) : timeout_ticks;
      if (quiet_count != QUIET_MAX) quiet_count = quiet_count + 1'b1;
      if (quiet_count >= limit) begin
        ctrl_active = 1'b0;
        gate_level  = 1'b0;
        fault       = level ? ERR_NOT_INSULATING : ERR_NOT_CONDUCTING;
      end
    end
  endfunction

  function automatic result_t predict_gate_result(logic [1:0] code, logic level);
    result_t r;
    case (code)
      OP_TICK: begin
        take_tick(level);
      end
      OP_ENABLE: begin
        if (fault == ERR_NONE) begin
          ctrl_active    = 1'b1;
          previous_level = level;
          follow_level(level);
        end
      end
      OP_DISABLE: begin
        ctrl_active = 1'b0;
      end
      default: begin
        fault = ERR_NONE;
      end
    endcase
    r.gate_drive      = gate_level;
    r.enabled         = ctrl_active;
    r.error_code      = fault;
    r.applied_percent = clamp_percent(percent_request);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      percent_request = PCT_RESET;
      timeout_ticks   = TIMEOUT_RESET;
      ctrl_active     = 1'b0;
      gate_level      = 1'b0;
      delay_left      = '0;
      delay_running   = 1'b0;
      quiet_count     = '0;
      previous_level  = 1'b0;
      fault           = ERR_NONE;
      expected_results.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PERCENT) percent_request = cfg_data[PCT_W-1:0];
        else timeout_ticks = cfg_data[QUIET_W-1:0];
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_gate_result(op, sense_level));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no prediction outstanding");
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (gate_drive !== want.gate_drive) begin
            $error("gate_drive: expected %0d, got %0d", want.gate_drive, gate_drive);
            errs++;
          end
          if (enabled !== want.enabled) begin
            $error("enabled: expected %0d, got %0d", want.enabled, enabled);
            errs++;
          end
          if (error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, error_code);
            errs++;
          end
          if (applied_percent !== want.applied_percent) begin
            $error("applied_percent: expected %0d, got %0d",
                   want.applied_percent, applied_percent);
            errs++;
          end
        end
      end
      fail_count  <= fail_count + errs;
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: dv/tb_triac_phase_angle_controller.sv
// ----------------------------------------------------------------------------
// Triac phase-angle controller testbench
// Drives timer ticks and control commands into the controller, shaped mostly
// as mains half-cycles of random length with glitches and stray commands, and
// lets the checker beside the block predict and compare every result beat.
// ----------------------------------------------------------------------------
module tb_triac_phase_angle_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import tpac_pkg::*;

  // A run with no accepted beat for this many cycles is taken as hung. The
  // longest legitimate quiet stretch is the deliberate receiver hold-off.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic               clk;
  logic               rst         = 1'b1;
  logic               cfg_we      = 1'b0;
  logic               cfg_index   = REG_PERCENT;
  logic [CFG_W-1:0]   cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic [1:0]         op          = OP_TICK;
  logic               sense_level = 1'b0;
  logic               out_stall   = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic               gate_drive;
  logic               enabled;
  logic [1:0]         error_code;
  logic [PCT_W-1:0]   applied_percent;

  int   fail_count;
  int   outstanding;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_request  = 1'b0;
  int   quiet_cycles  = 0;

  triac_phase_angle_controller dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .sense_level     (sense_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gate_drive      (gate_drive),
    .enabled         (enabled),
    .error_code      (error_code),
    .applied_percent (applied_percent)
  );

  tpac_gate_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .sense_level     (sense_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gate_drive      (gate_drive),
    .enabled         (enabled),
    .error_code      (error_code),
    .applied_percent (applied_percent),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side. Normally the stall is drawn afresh every cycle; when a long
  // hold-off is requested the receiver refuses results for a fixed stretch so
  // that both stages of the block fill and the input side backs up. The
  // hold-off is taken once.
  initial begin
    logic hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Hang detection: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Offers one beat, with a random gap in front of it, and returns at the
  // edge at which it is taken. Valid is left high so back-to-back beats need
  // no second assignment in the same step.
  task automatic send_beat(input logic [1:0] code, input logic level);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    sense_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic tick_run(input logic level, input int count);
    repeat (count) send_beat(OP_TICK, level);
  endtask

  // Stops offering and waits until every predicted result has come back.
  // Every beat produces a result, so an empty prediction store means idle;
  // the wait at the end only covers the result register settling.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges. Only called once drained.
  task automatic write_config(input logic [CFG_W-1:0] pct_word,
                              input logic [CFG_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PERCENT;
    cfg_data  <= pct_word;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most settings give a short firing delay (62..250 ticks) so that the gate
  // actually fires within a half-cycle; the rest take any percent at all. The
  // watchdog limit is either shorter than typical half-cycles or well beyond
  // them. The unused upper bits of the percent word are filled at random.
  task automatic random_config();
    logic [PCT_W-1:0]  pct;
    logic [QUIET_W-1:0] limit;
    if ($urandom_range(99) < 70) pct = PCT_W'($urandom_range(96, 127));
    else pct = PCT_W'($urandom_range(127));
    if ($urandom_range(1)) limit = QUIET_W'($urandom_range(1, 100));
    else limit = QUIET_W'($urandom_range(300, 2000));
    write_config({CFG_W'($urandom_range(8191)) << PCT_W} | CFG_W'(pct), limit);
  endtask

  // Mains-like sense waveform: level runs of random length, with a restart
  // (clear then enable) at some zero crossings. Glitch ticks and stray
  // commands are sprinkled in as noise.
  task automatic drive_mains(input int count);
    logic level;
    int   run_left;
    int   pick;
    level    = 1'($urandom_range(1));
    run_left = $urandom_range(1, 160);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 1) begin
        send_beat(OP_ENABLE, level);
      end else if (pick < 2) begin
        send_beat(OP_DISABLE, 1'($urandom_range(1)));
      end else if (pick < 3) begin
        send_beat(OP_CLEAR, 1'($urandom_range(1)));
      end else if (pick < 5) begin
        send_beat(OP_TICK, ~level);
      end else begin
        send_beat(OP_TICK, level);
        run_left--;
        if (run_left == 0) begin
          level    = ~level;
          run_left = $urandom_range(1, 160);
          if ($urandom_range(99) < 25) begin
            send_beat(OP_CLEAR, 1'($urandom_range(1)));
            send_beat(OP_ENABLE, level);
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 12;
    recv_idle_pct <= 54;

    // Reset values: percent 90 and the long watchdog. An edge while the
    // control is off, enable on a high level, disable leaving the gate alone,
    // a falling edge while off, clear with nothing latched, and re-enable.
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_ENABLE, 1'b1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_DISABLE, 1'b0);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_CLEAR, 1'b1);
    send_beat(OP_ENABLE, 1'b0);
    send_beat(OP_ENABLE, 1'b1);
    send_beat(OP_TICK, 1'b0);
    drain();

    // Percent above the range and a zero watchdog limit, which behaves as one:
    // the first quiet tick latches an error taken from the sensed level, and
    // enable is refused until the error is cleared.
    write_config(CFG_W'(127), '0);
    send_beat(OP_ENABLE, 1'b1);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_ENABLE, 1'b0);
    send_beat(OP_CLEAR, 1'b0);
    send_beat(OP_ENABLE, 1'b0);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_CLEAR, 1'b1);
    drain();

    // Percent zero (written with every upper bit set) and the largest limit.
    write_config(CFG_W'('hFFF80), '1);
    send_beat(OP_ENABLE, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_DISABLE, 1'b1);
    drain();

    // Shortest delay: the gate fires after 62 quiet ticks and survives a
    // disable until the next edge. A delay left running after disable expires
    // with the gate low.
    write_config(CFG_W'(99), CFG_W'(200));
    send_beat(OP_ENABLE, 1'b1);
    tick_run(1'b1, 62);
    send_beat(OP_DISABLE, 1'b0);
    send_beat(OP_TICK, 1'b1);
    send_beat(OP_TICK, 1'b0);
    send_beat(OP_ENABLE, 1'b1);
    send_beat(OP_DISABLE, 1'b1);
    tick_run(1'b1, 62);
    drain();

    // Longest delay, percent one, with the watchdog set beyond it. The delay
    // is loaded and counts down until a falling edge cuts it short.
    write_config(CFG_W'(1), CFG_W'(7000));
    send_beat(OP_ENABLE, 1'b1);
    tick_run(1'b1, 40);
    send_beat(OP_TICK, 1'b0);
    drain();

    random_config();
    drive_mains(100);
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    hold_request <= 1'b1;
    drive_mains(40);
    drain();

    // Phase two: the idling swaps sides.
    send_idle_pct = 54;
    recv_idle_pct <= 12;
    random_config();
    drive_mains(80);
    drain();
    random_config();
    drive_mains(80);
    drain();

    // Phase three: no idling at all.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_config(CFG_W'(100), '1);
    drive_mains(30);
    drain();
    random_config();
    drive_mains(60);
    // The sender stops until every result is back, then carries on.
    drain();
    drive_mains(30);
    drain();
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tpac_pkg.sv
rtl/core/tpac_cfg.sv
rtl/core/tpac_ctrl.sv
rtl/core/triac_phase_angle_controller.sv
dv/tpac_gate_checker.sv
dv/tb_triac_phase_angle_controller.sv
